@@ src/fgcc_pkg.sv @@
// ============================================================================
// fgcc_pkg
// Shared widths, codes and types of the functional graph cycle counter.
// ============================================================================
package fgcc_pkg;

    localparam int MAX_NODES = 1024;
    localparam int SUCC_W    = 11;
    localparam int IDX_W     = $clog2(MAX_NODES);
    localparam int CNT_W     = $clog2(MAX_NODES + 1);
    localparam int DEG_W     = $clog2(MAX_NODES + 2);
    localparam int CMP_W     = (SUCC_W > CNT_W) ? SUCC_W : CNT_W;

    // A peeled node carries this degree, which no live in-degree can reach.
    localparam logic [DEG_W-1:0] DEG_PEELED = {DEG_W{1'b1}};

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        logic [IDX_W-1:0] succ;
    } fgcc_load_t;

    typedef struct packed {
        logic             ok;
        logic [CNT_W-1:0] n;
    } fgcc_close_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [CNT_W-1:0] cycles;
    } fgcc_eng_stat_t;

endpackage

@@ src/functional_graph_cycle_count.sv @@
// ============================================================================
// functional_graph_cycle_count
// Counts the cycles of a functional graph loaded one node per transfer.
// ============================================================================
// Nodes are taken one per cycle while the block is loading and are numbered
// from 1 in arrival order; the transfer with last_node set closes the graph.
// A graph with a zero or out-of-range successor, or with more than MAX_NODES
// nodes, gives its error result without running the engine. Otherwise the
// engine counts in-degrees, peels the trees and scans for cycles, at a pace
// set by the single read port and registered read of each memory. No input is
// taken from the closing transfer until the result sits in the output
// register. There is no clearing pass after reset.
module functional_graph_cycle_count
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [fgcc_pkg::SUCC_W-1:0] successor,
    input  logic                        last_node,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [fgcc_pkg::SUCC_W-1:0] cycle_count,
    output logic                        bad_input
);
    import fgcc_pkg::*;

    localparam logic [1:0] ST_LOAD = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [SUCC_W-1:0] cycle_count_reg;
    logic              bad_input_reg;
    logic [SUCC_W-1:0] res_cycles_reg;
    logic [SUCC_W-1:0] res_cycles_next;
    logic              res_bad_reg;
    logic              res_bad_next;
    logic              take;
    logic              launch;
    logic              emit;

    fgcc_load_t     load;
    fgcc_close_t    verdict;
    fgcc_eng_stat_t stat;

    assign in_ready = (state_reg == ST_LOAD);
    assign take     = in_valid && in_ready;
    assign launch   = take && last_node && verdict.ok;
    assign emit     = (state_reg == ST_HOLD) && (!out_valid_reg || out_ready);

    fgcc_intake u_intake
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .last_node (last_node),
        .successor (successor),
        .load      (load),
        .verdict   (verdict)
    );

    fgcc_engine u_engine
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (load),
        .start   (launch),
        .start_n (verdict.n),
        .stat    (stat)
    );

    always_comb
    begin
        state_next      = state_reg;
        res_cycles_next = res_cycles_reg;
        res_bad_next    = res_bad_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (take && last_node)
                begin
                    if (verdict.ok)
                    begin
                        state_next = ST_RUN;
                    end
                    else
                    begin
                        res_cycles_next = '0;
                        res_bad_next    = 1'b1;
                        state_next      = ST_HOLD;
                    end
                end
            end
            ST_RUN:
            begin
                if (stat.done)
                begin
                    res_cycles_next = SUCC_W'(stat.cycles);
                    res_bad_next    = 1'b0;
                    state_next      = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (emit)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_cycles_reg <= res_cycles_next;
        res_bad_reg    <= res_bad_next;
        if (emit)
        begin
            cycle_count_reg <= res_cycles_reg;
            bad_input_reg   <= res_bad_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign cycle_count = cycle_count_reg;
    assign bad_input   = bad_input_reg;

`ifndef SYNTHESIS
    a_ready_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && stat.busy))
        else $error("Input taken while the engine is busy.");

    a_done_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        stat.done |-> (state_reg == ST_RUN))
        else $error("Engine finished outside the run phase.");

    a_close_stalls_input: assert property (@(posedge clk) disable iff (!rst_n)
        (take && last_node) |=> !in_ready)
        else $error("Input taken right after a closing transfer.");
`endif

endmodule

@@ src/fgcc_intake.sv @@
// ============================================================================
// fgcc_intake
// Numbers arriving nodes, validates successors on the fly and produces the
// memory write for each stored node and the verdict when a graph closes.
// ============================================================================
module fgcc_intake
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 take,
    input  logic                 last_node,
    input  logic [fgcc_pkg::SUCC_W-1:0] successor,
    output fgcc_pkg::fgcc_load_t  load,
    output fgcc_pkg::fgcc_close_t verdict
);
    import fgcc_pkg::*;

    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              err_reg;
    logic              err_next;
    logic [SUCC_W-1:0] max_reg;
    logic [SUCC_W-1:0] max_next;
    logic              full;

    assign full = (cnt_reg == CNT_W'(MAX_NODES));

    always_comb
    begin
        cnt_next = cnt_reg;
        err_next = err_reg;
        max_next = max_reg;
        if (full)
        begin
            err_next = 1'b1;
        end
        else
        begin
            cnt_next = cnt_reg + CNT_W'(1);
            if (successor == '0)
            begin
                err_next = 1'b1;
            end
            if (successor > max_reg)
            begin
                max_next = successor;
            end
        end
    end

    assign load.en   = take && !full;
    assign load.idx  = IDX_W'(cnt_reg);
    assign load.succ = IDX_W'(successor - SUCC_W'(1));

    assign verdict.ok = !err_next && (CMP_W'(max_next) <= CMP_W'(cnt_next));
    assign verdict.n  = cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            err_reg <= 1'b0;
            max_reg <= '0;
        end
        else if (take)
        begin
            if (last_node)
            begin
                cnt_reg <= '0;
                err_reg <= 1'b0;
                max_reg <= '0;
            end
            else
            begin
                cnt_reg <= cnt_next;
                err_reg <= err_next;
                max_reg <= max_next;
            end
        end
    end

endmodule

@@ src/fgcc_engine.sv @@
// ============================================================================
// fgcc_engine
// Holds the successor and degree memories and sequences the degree count,
// the peeling of in-degree-zero chains and the cycle scan over them.
// ============================================================================
module fgcc_engine
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  fgcc_pkg::fgcc_load_t     load,
    input  logic                     start,
    input  logic [fgcc_pkg::CNT_W-1:0] start_n,
    output fgcc_pkg::fgcc_eng_stat_t stat
);
    import fgcc_pkg::*;

    localparam logic [3:0] E_IDLE     = 4'd0;
    localparam logic [3:0] E_CNT_RS   = 4'd1;
    localparam logic [3:0] E_CNT_RD   = 4'd2;
    localparam logic [3:0] E_CNT_WR   = 4'd3;
    localparam logic [3:0] E_PEEL_RD  = 4'd4;
    localparam logic [3:0] E_PEEL_CHK = 4'd5;
    localparam logic [3:0] E_PEEL_S   = 4'd6;
    localparam logic [3:0] E_PEEL_DEC = 4'd7;
    localparam logic [3:0] E_SCAN_RD  = 4'd8;
    localparam logic [3:0] E_SCAN_CHK = 4'd9;
    localparam logic [3:0] E_WALK     = 4'd10;
    localparam logic [3:0] E_FIN      = 4'd11;

    logic [IDX_W-1:0] succ_mem [MAX_NODES];
    logic [DEG_W-1:0] deg_mem  [MAX_NODES];

    logic [IDX_W-1:0] succ_rd_reg;
    logic [DEG_W-1:0] deg_rd_reg;
    logic [IDX_W-1:0] succ_raddr;
    logic [IDX_W-1:0] deg_raddr;
    logic             deg_we;
    logic [IDX_W-1:0] deg_waddr;
    logic [DEG_W-1:0] deg_wdata;

    logic [3:0]       state_reg;
    logic [3:0]       state_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic [IDX_W-1:0] last_reg;
    logic [IDX_W-1:0] last_next;
    logic [IDX_W-1:0] node_reg;
    logic [IDX_W-1:0] node_next;
    logic [CNT_W-1:0] cyc_reg;
    logic [CNT_W-1:0] cyc_next;
    logic [DEG_W-1:0] deg_dec;
    logic             at_last;

    assign deg_dec = deg_rd_reg - DEG_W'(1);
    assign at_last = (idx_reg == last_reg);

    always_ff @(posedge clk)
    begin
        if (load.en)
        begin
            succ_mem[load.idx] <= load.succ;
        end
        succ_rd_reg <= succ_mem[succ_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (deg_we)
        begin
            deg_mem[deg_waddr] <= deg_wdata;
        end
        deg_rd_reg <= deg_mem[deg_raddr];
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        last_next  = last_reg;
        node_next  = node_reg;
        cyc_next   = cyc_reg;
        succ_raddr = idx_reg;
        deg_raddr  = idx_reg;
        deg_we     = 1'b0;
        deg_waddr  = idx_reg;
        deg_wdata  = '0;
        unique case (state_reg)
            E_IDLE:
            begin
                deg_we    = load.en;
                deg_waddr = load.idx;
                if (start)
                begin
                    idx_next   = '0;
                    last_next  = IDX_W'(start_n - CNT_W'(1));
                    cyc_next   = '0;
                    state_next = E_CNT_RS;
                end
            end
            E_CNT_RS:
            begin
                state_next = E_CNT_RD;
            end
            E_CNT_RD:
            begin
                deg_raddr  = succ_rd_reg;
                node_next  = succ_rd_reg;
                state_next = E_CNT_WR;
            end
            E_CNT_WR:
            begin
                deg_we    = 1'b1;
                deg_waddr = node_reg;
                deg_wdata = deg_rd_reg + DEG_W'(1);
                if (at_last)
                begin
                    idx_next   = '0;
                    state_next = E_PEEL_RD;
                end
                else
                begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = E_CNT_RS;
                end
            end
            E_PEEL_RD:
            begin
                state_next = E_PEEL_CHK;
            end
            E_PEEL_CHK:
            begin
                if (deg_rd_reg == '0)
                begin
                    deg_we     = 1'b1;
                    deg_wdata  = DEG_PEELED;
                    state_next = E_PEEL_S;
                end
                else if (at_last)
                begin
                    idx_next   = '0;
                    state_next = E_SCAN_RD;
                end
                else
                begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = E_PEEL_RD;
                end
            end
            E_PEEL_S:
            begin
                deg_raddr  = succ_rd_reg;
                node_next  = succ_rd_reg;
                state_next = E_PEEL_DEC;
            end
            E_PEEL_DEC:
            begin
                deg_we     = 1'b1;
                deg_waddr  = node_reg;
                succ_raddr = node_reg;
                if (deg_dec == '0)
                begin
                    deg_wdata  = DEG_PEELED;
                    state_next = E_PEEL_S;
                end
                else
                begin
                    deg_wdata = deg_dec;
                    if (at_last)
                    begin
                        idx_next   = '0;
                        state_next = E_SCAN_RD;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = E_PEEL_RD;
                    end
                end
            end
            E_SCAN_RD:
            begin
                state_next = E_SCAN_CHK;
            end
            E_SCAN_CHK:
            begin
                if (deg_rd_reg == DEG_W'(1))
                begin
                    cyc_next   = cyc_reg + CNT_W'(1);
                    state_next = E_WALK;
                end
                else if (at_last)
                begin
                    state_next = E_FIN;
                end
                else
                begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = E_SCAN_RD;
                end
            end
            E_WALK:
            begin
                if (succ_rd_reg == idx_reg)
                begin
                    if (at_last)
                    begin
                        state_next = E_FIN;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = E_SCAN_RD;
                    end
                end
                else
                begin
                    deg_we     = 1'b1;
                    deg_waddr  = succ_rd_reg;
                    succ_raddr = succ_rd_reg;
                end
            end
            E_FIN:
            begin
                state_next = E_IDLE;
            end
            default:
            begin
                state_next = E_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= E_IDLE;
            cyc_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cyc_reg   <= cyc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        last_reg <= last_next;
        node_reg <= node_next;
    end

    assign stat.busy   = (state_reg != E_IDLE);
    assign stat.done   = (state_reg == E_FIN);
    assign stat.cycles = cyc_reg;

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Self-checking testbench of the functional graph cycle counter.
// ============================================================================
// Graphs are sent one node per transfer, and each closing transfer is
// predicted by peeling trees off the stored graph and counting what is left.
// Small hand-made graphs and the malformed cases run first. They are followed
// by random graphs of mixed shape and size, some with bad successors. Both
// sides of the block stall at random.
module tb_top;

    localparam int NODE_LIMIT   = fgcc_pkg::MAX_NODES;
    localparam int SUCC_W       = fgcc_pkg::SUCC_W;
    localparam int IDLE_MAX     = 15;
    localparam int RANDOM_ITEMS = 930;
    localparam int DRAIN_CYCLES = 64;

    typedef struct packed {
        logic [SUCC_W-1:0] cycle_count;
        logic              bad_input;
    } graph_result_t;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_ready;
    logic [SUCC_W-1:0] successor = '0;
    logic              last_node = 1'b0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [SUCC_W-1:0] cycle_count;
    logic              bad_input;

    int unsigned       graph_next [0:NODE_LIMIT];
    int unsigned       node_degree[0:NODE_LIMIT];
    int unsigned       loaded_nodes  = 0;
    bit                overflow_seen = 1'b0;
    graph_result_t     expected_results[$];

    bit                idle_off      = 1'b0;
    int                ready_hold    = 3;
    int unsigned       error_count   = 0;
    int unsigned       nodes_sent    = 0;
    int unsigned       graphs_closed = 0;
    int unsigned       error_graphs  = 0;
    int unsigned       random_items  = 0;
    graph_result_t     oldest_result;
    int unsigned       out_stall;

    functional_graph_cycle_count i_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .successor   (successor),
        .last_node   (last_node),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .cycle_count (cycle_count),
        .bad_input   (bad_input)
    );

    always #5 clk = ~clk;

    function automatic int unsigned count_graph_cycles(input int unsigned n);
        int unsigned k;
        int unsigned v;
        int unsigned s;
        int unsigned walk;
        int unsigned steps;
        int unsigned cycles;
        int unsigned peel[$];
        cycles = 0;
        for (k = 0; k <= NODE_LIMIT; k++)
            node_degree[k] = 0;
        for (k = 1; k <= n; k++)
            node_degree[graph_next[k]]++;
        for (k = 1; k <= n; k++)
            if (node_degree[k] == 0)
                peel.push_back(k);
        while (peel.size() != 0)
        begin
            v = peel.pop_front();
            s = graph_next[v];
            if (node_degree[s] > 0)
            begin
                node_degree[s]--;
                if (node_degree[s] == 0)
                    peel.push_back(s);
            end
        end
        for (k = 1; k <= n; k++)
        begin
            if (node_degree[k] == 1)
            begin
                walk  = graph_next[k];
                steps = 0;
                while (walk != k && steps < n)
                begin
                    node_degree[walk] = 0;
                    walk = graph_next[walk];
                    steps++;
                end
                cycles++;
            end
        end
        return cycles;
    endfunction

    function automatic void absorb_node(input logic [SUCC_W-1:0] succ, input logic last);
        graph_result_t res;
        bit            graph_ok;
        int unsigned   k;
        if (loaded_nodes >= NODE_LIMIT)
            overflow_seen = 1'b1;
        else
        begin
            loaded_nodes++;
            graph_next[loaded_nodes] = succ;
        end
        if (last)
        begin
            graph_ok = !overflow_seen && loaded_nodes > 0;
            for (k = 1; k <= loaded_nodes; k++)
                if (graph_next[k] == 0 || graph_next[k] > loaded_nodes)
                    graph_ok = 1'b0;
            res.bad_input   = !graph_ok;
            res.cycle_count = graph_ok ? SUCC_W'(count_graph_cycles(loaded_nodes)) : '0;
            expected_results.push_back(res);
            graphs_closed++;
            if (!graph_ok)
                error_graphs++;
            loaded_nodes  = 0;
            overflow_seen = 1'b0;
        end
    endfunction

    task automatic send_node(input logic [SUCC_W-1:0] succ, input logic last);
        int unsigned gap;
        gap = idle_off ? 0 : $urandom_range(0, IDLE_MAX);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        successor <= succ;
        last_node <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        absorb_node(succ, last);
        nodes_sent++;
    endtask

    task automatic send_graph(input int unsigned succ_list[$]);
        int unsigned k;
        for (k = 0; k < succ_list.size(); k++)
            send_node(SUCC_W'(succ_list[k]), k == succ_list.size() - 1);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result transfer with no expected result: cycle_count %0d, bad_input %0d",
                           cycle_count, bad_input);
                    error_count++;
                end
                else
                begin
                    oldest_result = expected_results.pop_front();
                    if (cycle_count !== oldest_result.cycle_count)
                    begin
                        $error("cycle_count: expected %0d, actual %0d",
                               oldest_result.cycle_count, cycle_count);
                        error_count++;
                    end
                    if (bad_input !== oldest_result.bad_input)
                    begin
                        $error("bad_input: expected %0d, actual %0d",
                               oldest_result.bad_input, bad_input);
                        error_count++;
                    end
                end
                out_stall = idle_off ? 0 : $urandom_range(0, IDLE_MAX);
                if (out_stall != 0)
                begin
                    out_ready  <= 1'b0;
                    ready_hold <= out_stall - 1;
                end
            end
            else if (!out_ready)
            begin
                if (ready_hold == 0)
                    out_ready <= 1'b1;
                else
                    ready_hold <= ready_hold - 1;
            end
        end
    end

    task automatic test_small_graphs();
        idle_off = 1'b0;
        send_graph('{1});
        send_graph('{0});
        send_graph('{2, 1});
        send_graph('{2, 3, 3});
        send_graph('{1, 4, 2});
        send_graph('{2047});
        send_graph('{1024});
        send_graph('{1, 2, 3, 4});
        send_graph('{3, 3, 1, 5, 4});
    endtask

    task automatic test_random_graphs();
        int unsigned plan[$];
        int unsigned n;
        int unsigned k;
        int unsigned kind;
        int unsigned pick;
        int unsigned start;
        int unsigned seg;
        while (random_items < RANDOM_ITEMS)
        begin
            idle_off = ($urandom_range(0, 7) == 0);
            kind     = $urandom_range(0, 99);
            pick     = $urandom_range(0, 99);
            if (pick < 60)
                n = $urandom_range(1, 8);
            else if (pick < 90)
                n = $urandom_range(9, 40);
            else
                n = $urandom_range(41, 300);
            if (n > RANDOM_ITEMS - random_items)
                n = RANDOM_ITEMS - random_items;
            plan.delete();
            if (kind < 45 || (kind >= 80 && kind < 92))
            begin
                for (k = 1; k <= n; k++)
                    plan.push_back($urandom_range(1, n));
                if (kind >= 80)
                    plan[$urandom_range(0, n - 1)] =
                        $urandom_range(0, 1) ? 0 : $urandom_range(n + 1, 2047);
            end
            else if (kind < 80)
            begin
                start = 1;
                while (start <= n)
                begin
                    seg = $urandom_range(1, (n - start + 1 < 8) ? n - start + 1 : 8);
                    for (k = start; k < start + seg; k++)
                        plan.push_back((k == start + seg - 1) ? start : k + 1);
                    start = start + seg;
                end
                for (k = 0; k < n; k++)
                    if ($urandom_range(0, 3) == 0)
                        plan[k] = $urandom_range(1, n);
            end
            else
            begin
                n = $urandom_range(1, 8);
                for (k = 1; k <= n; k++)
                    plan.push_back($urandom_range(0, 2047));
            end
            send_graph(plan);
            random_items += n;
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_small_graphs();
        test_random_graphs();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d nodes in %0d graphs, %0d of which were malformed or too large.",
                 nodes_sent, graphs_closed, error_graphs);
        if (error_count == 0)
            $display("[functional_graph_cycle_count] OK");
        else
            $display("[functional_graph_cycle_count] ERROR");
        $finish;
    end

    initial
    begin
        #(5_000_000);
        $display("[functional_graph_cycle_count] ERROR");
        $finish;
    end

endmodule
